>>> rtl/cube_map_face_texel_address_assert.svh
// assertion macros shared by the cube map texel address block
`ifndef CUBE_MAP_FACE_TEXEL_ADDRESS_ASSERT_SVH
`define CUBE_MAP_FACE_TEXEL_ADDRESS_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked on every clk edge out of reset
`define CMFTA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CMFTA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define CMFTA_ASSERT_IMP(lbl, ante, cons, msg)
`define CMFTA_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

>>> rtl/cmfta_pkg.sv
package cmfta_pkg;

	localparam int DIR_W    = 16;
	localparam int MAG_W    = 16;
	localparam int NUM_W    = 17;
	localparam int TEXEL_W  = 12;
	localparam int CFG_W    = 13;
	localparam int CFG_AW   = 2;

	localparam logic [CFG_W-1:0] SIZE_RESET = 13'd256;

	localparam logic [CFG_AW-1:0] REG_FACE_WIDTH  = 2'd0;
	localparam logic [CFG_AW-1:0] REG_FACE_HEIGHT = 2'd1;

	typedef enum logic [2:0] {
		FACE_FRONT  = 3'd0,
		FACE_BACK   = 3'd1,
		FACE_TOP    = 3'd2,
		FACE_BOTTOM = 3'd3,
		FACE_LEFT   = 3'd4,
		FACE_RIGHT  = 3'd5
	} face_t;

	typedef struct packed {
		logic  zero;
		face_t face;
	} side_t;

	// u coordinate runs against the minor axis on these faces
	function automatic logic u_negate(face_t f);
		return (f == FACE_FRONT) || (f == FACE_RIGHT);
	endfunction

	function automatic logic v_negate(face_t f);
		return (f == FACE_BOTTOM);
	endfunction

endpackage

>>> rtl/cmfta_div.sv
`include "cube_map_face_texel_address_assert.svh"

module cmfta_div #(
	parameter int QW = 13,
	parameter int NW = 30,
	parameter int DW = 17
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	input  logic [QW-1:0] size,
	output logic          out_valid,
	output logic [QW-1:0] quot
);

	// one quotient bit per stage, msb first
	logic [QW:1]   vld_s;
	logic [NW-1:0] rem_s  [1:QW];
	logic [QW-1:0] quo_s  [1:QW];
	logic [DW-1:0] dvs_s  [1:QW];
	logic [QW-1:0] size_s [1:QW];

	logic          res_vld_q;
	logic [QW-1:0] res_quot_q;
	logic [QW-1:0] res_size_q;

	for (genvar k = 0; k < QW; k++) begin : g_stage
		localparam int BIT = QW - 1 - k;

		logic          v_in;
		logic [NW-1:0] r_in;
		logic [QW-1:0] q_in;
		logic [DW-1:0] d_in;
		logic [QW-1:0] s_in;
		logic [NW-1:0] shd;
		logic          ge;

		if (k == 0) begin : g_first
			assign v_in = in_valid;
			assign r_in = dividend;
			assign q_in = '0;
			assign d_in = divisor;
			assign s_in = size;
		end else begin : g_next
			assign v_in = vld_s[k];
			assign r_in = rem_s[k];
			assign q_in = quo_s[k];
			assign d_in = dvs_s[k];
			assign s_in = size_s[k];
		end

		assign shd = NW'(d_in) << BIT;
		assign ge  = (r_in >= shd);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (v_in) begin
				rem_s[k+1]  <= ge ? (r_in - shd) : r_in;
				quo_s[k+1]  <= q_in | (ge ? (QW'(1) << BIT) : QW'(0));
				dvs_s[k+1]  <= d_in;
				size_s[k+1] <= s_in;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else begin
			res_vld_q <= vld_s[QW];
		end
	end

	// far edge gives quotient == size, clamp to the last texel
	always_ff @(posedge clk) begin
		if (vld_s[QW]) begin
			res_quot_q <= (quo_s[QW] >= size_s[QW]) ? (size_s[QW] - QW'(1)) : quo_s[QW];
			res_size_q <= size_s[QW];
		end
	end

	assign out_valid = res_vld_q;
	assign quot      = res_quot_q;

	`CMFTA_ASSERT_IMP(a_rem_below_divisor, vld_s[QW], rem_s[QW] < NW'(dvs_s[QW]), "remainder not reduced below divisor")
	`CMFTA_ASSERT_NXT(a_valid_reaches_out, vld_s[QW], res_vld_q, "last stage word lost")
	`CMFTA_ASSERT_IMP(a_quot_in_face, res_vld_q, res_quot_q < res_size_q, "texel beyond face size")

endmodule

>>> rtl/cube_map_face_texel_address.sv
// Cube map face select and texel address.
// A direction (dir_x, dir_y, dir_z, signed Q2.14) is taken at each clock edge
// where start is high; busy is always low, so a new direction may be given in
// every cycle. The face of the largest magnitude is chosen and the two minor
// components are mapped to a column and row of that face, saturated to the
// face size minus one. An all-zero direction gives face 1, texel 0 and sets
// zero_vector.
// done pulses for one cycle as a word leaves the clamp register of the
// dividers, with face_index, texel_col, texel_row and zero_vector valid in
// that cycle. Throughput is one word per cycle; the pipeline is four front
// stages (register, face pick, coordinate add, size multiply) and a
// one-bit-per-stage divider pair with a clamp register at its end.
// face_width and face_height must be written through cfg_we/cfg_addr/cfg_wdata
// while no word is in flight; the block itself does not enforce this. A size
// of zero acts as one and a size above MAX_FACE_SIZE acts as MAX_FACE_SIZE.
// Reset empties the pipeline and sets both sizes to 256. The receiver takes
// every result as it comes.

`include "cube_map_face_texel_address_assert.svh"

module cube_map_face_texel_address
	import cmfta_pkg::*;
#(
	parameter int MAX_FACE_SIZE = 4096
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_AW-1:0]        cfg_addr,
	input  logic [CFG_W-1:0]         cfg_wdata,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [DIR_W-1:0]  dir_x,
	input  logic signed [DIR_W-1:0]  dir_y,
	input  logic signed [DIR_W-1:0]  dir_z,
	output logic                     done,
	output logic [2:0]               face_index,
	output logic [TEXEL_W-1:0]       texel_col,
	output logic [TEXEL_W-1:0]       texel_row,
	output logic                     zero_vector
);

	localparam int SW = $clog2(MAX_FACE_SIZE + 1);
	localparam int NW = NUM_W + SW;

	logic [CFG_W-1:0] face_width_q, face_height_q;
	logic [SW-1:0]    width_eff, height_eff;
	logic [31:0]      width_ext, height_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_width_q  <= SIZE_RESET;
			face_height_q <= SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_FACE_WIDTH:  face_width_q  <= cfg_wdata;
				REG_FACE_HEIGHT: face_height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign width_ext  = 32'(face_width_q);
	assign height_ext = 32'(face_height_q);

	always_comb begin
		if (face_width_q == '0) begin
			width_eff = SW'(1);
		end else if (width_ext > 32'(MAX_FACE_SIZE)) begin
			width_eff = SW'(MAX_FACE_SIZE);
		end else begin
			width_eff = width_ext[SW-1:0];
		end
		if (face_height_q == '0) begin
			height_eff = SW'(1);
		end else if (height_ext > 32'(MAX_FACE_SIZE)) begin
			height_eff = SW'(MAX_FACE_SIZE);
		end else begin
			height_eff = height_ext[SW-1:0];
		end
	end

	assign busy = 1'b0;

	// stage 1: capture and magnitudes
	logic                    vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [DIR_W-1:0] dir_x_s1, dir_y_s1, dir_z_s1;
	logic [MAG_W-1:0]        mag_x_s1, mag_y_s1, mag_z_s1;
	logic                    zero_s1;
	logic [SW-1:0]           width_s1, height_s1;
	logic [MAG_W-1:0]        mag_x_c, mag_y_c, mag_z_c;

	assign mag_x_c = dir_x[DIR_W-1] ? (~dir_x + 1'b1) : dir_x;
	assign mag_y_c = dir_y[DIR_W-1] ? (~dir_y + 1'b1) : dir_y;
	assign mag_z_c = dir_z[DIR_W-1] ? (~dir_z + 1'b1) : dir_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			dir_x_s1  <= dir_x;
			dir_y_s1  <= dir_y;
			dir_z_s1  <= dir_z;
			mag_x_s1  <= mag_x_c;
			mag_y_s1  <= mag_y_c;
			mag_z_s1  <= mag_z_c;
			zero_s1   <= (dir_x == '0) && (dir_y == '0) && (dir_z == '0);
			width_s1  <= width_eff;
			height_s1 <= height_eff;
		end
	end

	// stage 2: face pick and axis select; ties fall to the later branch
	face_t                   face_c;
	logic [MAG_W-1:0]        major_c;
	logic signed [DIR_W-1:0] minor_u_c, minor_v_c;

	always_comb begin
		if (mag_x_s1 > mag_y_s1) begin
			if (mag_x_s1 > mag_z_s1) begin
				face_c = (dir_x_s1 > 0) ? FACE_LEFT : FACE_RIGHT;
			end else begin
				face_c = (dir_z_s1 > 0) ? FACE_FRONT : FACE_BACK;
			end
		end else if (mag_y_s1 > mag_z_s1) begin
			face_c = (dir_y_s1 > 0) ? FACE_TOP : FACE_BOTTOM;
		end else begin
			face_c = (dir_z_s1 > 0) ? FACE_FRONT : FACE_BACK;
		end

		case (face_c)
			FACE_TOP, FACE_BOTTOM: begin
				major_c   = mag_y_s1;
				minor_u_c = dir_x_s1;
				minor_v_c = dir_z_s1;
			end
			FACE_LEFT, FACE_RIGHT: begin
				major_c   = mag_x_s1;
				minor_u_c = dir_z_s1;
				minor_v_c = dir_y_s1;
			end
			default: begin
				major_c   = mag_z_s1;
				minor_u_c = dir_x_s1;
				minor_v_c = dir_y_s1;
			end
		endcase
	end

	side_t                   side_s2, side_s3, side_s4;
	logic [MAG_W-1:0]        major_s2;
	logic signed [DIR_W-1:0] minor_u_s2, minor_v_s2;
	logic                    neg_u_s2, neg_v_s2;
	logic [SW-1:0]           width_s2, height_s2;

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			side_s2.zero <= zero_s1;
			side_s2.face <= face_c;
			major_s2     <= major_c;
			minor_u_s2   <= minor_u_c;
			minor_v_s2   <= minor_v_c;
			neg_u_s2     <= u_negate(face_c);
			neg_v_s2     <= v_negate(face_c);
			width_s2     <= width_s1;
			height_s2    <= height_s1;
		end
	end

	// stage 3: numerators major +/- minor, divisor 2*major
	logic signed [NUM_W:0] maj_ext, min_u_ext, min_v_ext, sum_u, sum_v;
	logic [NUM_W-1:0]      num_u_s3, num_v_s3, divisor_s3;
	logic [SW-1:0]         width_s3, height_s3;

	assign maj_ext   = $signed({2'b00, major_s2});
	assign min_u_ext = $signed({{2{minor_u_s2[DIR_W-1]}}, minor_u_s2});
	assign min_v_ext = $signed({{2{minor_v_s2[DIR_W-1]}}, minor_v_s2});
	assign sum_u     = neg_u_s2 ? (maj_ext - min_u_ext) : (maj_ext + min_u_ext);
	assign sum_v     = neg_v_s2 ? (maj_ext - min_v_ext) : (maj_ext + min_v_ext);

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			side_s3    <= side_s2;
			num_u_s3   <= sum_u[NUM_W] ? '0 : sum_u[NUM_W-1:0];
			num_v_s3   <= sum_v[NUM_W] ? '0 : sum_v[NUM_W-1:0];
			// zero direction divides 0 by 1 so both texels come out 0
			divisor_s3 <= (major_s2 == '0) ? NUM_W'(1) : {major_s2, 1'b0};
			width_s3   <= width_s2;
			height_s3  <= height_s2;
		end
	end

	// stage 4: scale numerators by face size
	logic [NW-1:0]    dividend_u_s4, dividend_v_s4;
	logic [NUM_W-1:0] divisor_s4;
	logic [SW-1:0]    width_s4, height_s4;

	always_ff @(posedge clk) begin
		if (vld_s3) begin
			side_s4       <= side_s3;
			dividend_u_s4 <= NW'(num_u_s3) * NW'(width_s3);
			dividend_v_s4 <= NW'(num_v_s3) * NW'(height_s3);
			divisor_s4    <= divisor_s3;
			width_s4      <= width_s3;
			height_s4     <= height_s3;
		end
	end

	logic          col_vld, row_vld;
	logic [SW-1:0] col_quot, row_quot;

	cmfta_div #(.QW(SW), .NW(NW), .DW(NUM_W)) u_div_col (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s4),
		.dividend  (dividend_u_s4),
		.divisor   (divisor_s4),
		.size      (width_s4),
		.out_valid (col_vld),
		.quot      (col_quot)
	);

	cmfta_div #(.QW(SW), .NW(NW), .DW(NUM_W)) u_div_row (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s4),
		.dividend  (dividend_v_s4),
		.divisor   (divisor_s4),
		.size      (height_s4),
		.out_valid (row_vld),
		.quot      (row_quot)
	);

	// face and zero flag ride alongside the dividers
	side_t side_dly_q [SW+1];

	always_ff @(posedge clk) begin
		side_dly_q[0] <= side_s4;
		for (int j = 1; j <= SW; j++) begin
			side_dly_q[j] <= side_dly_q[j-1];
		end
	end

	logic [SW+TEXEL_W-1:0] col_ext, row_ext;

	assign col_ext     = {{TEXEL_W{1'b0}}, col_quot};
	assign row_ext     = {{TEXEL_W{1'b0}}, row_quot};
	assign done        = col_vld;
	assign face_index  = side_dly_q[SW].face;
	assign zero_vector = side_dly_q[SW].zero;
	assign texel_col   = col_ext[TEXEL_W-1:0];
	assign texel_row   = row_ext[TEXEL_W-1:0];

	`CMFTA_ASSERT_IMP(a_div_lockstep, 1'b1, col_vld == row_vld, "column and row dividers out of step")
	`CMFTA_ASSERT_NXT(a_accept_enters, start && !busy, vld_s1, "accepted word did not enter stage 1")
	`CMFTA_ASSERT_IMP(a_zero_result, done && zero_vector, texel_col == '0 && texel_row == '0 && face_index == 3'(FACE_BACK), "zero direction gave a nonzero result")

endmodule
